[rtl/sil_pkg.sv]
`timescale 1ns / 1ps

package sil_pkg;

	localparam int KEY_W = 32;
	localparam int POS_W = 4;
	localparam int OUT_CNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_PAST_END = 2'd2
	} status_t;

	// command broadcast from the controller to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [KEY_W-1:0] key;
	} sil_cmd_t;

	// signed order of two keys: true when a <= b
	function automatic logic key_le(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		key_le = $signed(a) <= $signed(b);
	endfunction

endpackage

[rtl/sil_cell.sv]
`timescale 1ns / 1ps

module sil_cell
	import sil_pkg::*;
(
	input  logic             clk,
	input  sil_cmd_t         cmd,
	input  logic             occ,
	input  logic [KEY_W-1:0] left_key,
	input  logic             left_le,
	input  logic [KEY_W-1:0] right_key,
	output logic [KEY_W-1:0] key,
	output logic             le,
	output logic             eq
);

	logic [KEY_W-1:0] key_q;
	logic             ge;

	// compare the held entry with the broadcast key
	always_comb begin
		le = occ && key_le(key_q, cmd.key);
		ge = occ && key_le(cmd.key, key_q);
		eq = occ && (key_q == cmd.key);
	end

	assign key = key_q;

	// insert: cells past the slot shift right, the slot takes the new key
	// remove: cells at or above the key shift left by one
	always_ff @(posedge clk) begin
		if (cmd.ins && !le) begin
			key_q <= left_le ? cmd.key : left_key;
		end else if (cmd.del && ge) begin
			key_q <= right_key;
		end
	end

endmodule

[rtl/sorted_insertion_list.sv]
`timescale 1ns / 1ps

// Sorted insertion list: holds up to CAPACITY signed 32-bit keys in ascending
// order in a row of cells, each with one entry, a comparator and links to its
// two neighbors. Insert, read and the unused operation code finish as they are
// accepted, so such words are accepted back to back while the result word is
// taken. A remove first takes the key; then the chain closes the gap by one
// place per cycle, once for each entry equal to the key, and a last step sees
// that no equal entry is left. The result word is registered and appears
// the cycle after the operation finishes. An insert into a full list is
// refused with status full; a read at or beyond the count gives status past
// end and a zero value. Counts are reported as their low five bits.
module sorted_insertion_list
	import sil_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // key_value[31:0], position[35:32], zero pad
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // read_value[31:0], removed_count[36:32],
	                                    // entry_count[41:37], is_empty[42], zero pad
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
	localparam int RD_IW = $clog2(RD_N);

	typedef enum logic {
		S_IDLE,
		S_REMOVE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   removed_q;
	logic [KEY_W-1:0]   op_key_q;
	logic               m_valid_q;
	status_t            m_status_q;
	logic [KEY_W-1:0]   m_value_q;
	logic [OUT_CNT_W-1:0] m_removed_q;
	logic [OUT_CNT_W-1:0] m_entry_q;
	logic               m_empty_q;

	sil_cmd_t           cmd;
	logic [KEY_W-1:0]   key_vec [CAPACITY];
	logic [CAPACITY-1:0] le_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic [CAPACITY-1:0] occ_vec;
	logic [KEY_W-1:0]   rd_taps [RD_N];

	logic               acc;
	logic               full;
	logic               any_eq;
	logic               past_end;
	op_t                op;
	logic [KEY_W-1:0]   in_key;
	logic [POS_W-1:0]   in_pos;
	logic [CNT_W-1:0]   count_inc;
	logic [CNT_W-1:0]   count_dec;
	logic [CNT_W-1:0]   removed_inc;

	logic               res_load;
	status_t            res_status;
	logic [KEY_W-1:0]   res_value;
	logic [OUT_CNT_W-1:0] res_removed;
	logic [OUT_CNT_W-1:0] res_entry;
	logic               res_empty;

	assign op     = op_t'(s_axis_tuser);
	assign in_key = s_axis_tdata[KEY_W-1:0];
	assign in_pos = s_axis_tdata[KEY_W+POS_W-1:KEY_W];

	assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign full          = count_q >= CNT_W'(CAPACITY);
	assign any_eq        = |eq_vec;
	assign count_inc     = count_q + 1'b1;
	assign count_dec     = count_q - 1'b1;
	assign removed_inc   = removed_q + 1'b1;

	// broadcast the operation to the chain
	always_comb begin
		cmd.key = (state_q == S_REMOVE) ? op_key_q : in_key;
		cmd.ins = acc && (op == OP_INSERT) && !full;
		cmd.del = (state_q == S_REMOVE) && any_eq;
	end

	// build the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0] left_key;
		logic             left_le;
		logic [KEY_W-1:0] right_key;

		assign occ_vec[i] = CNT_W'(i) < count_q;

		if (i == 0) begin : g_first
			assign left_key = '0;
			assign left_le  = 1'b1;
		end else begin : g_inner_l
			assign left_key = key_vec[i-1];
			assign left_le  = le_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key = '0;
		end else begin : g_inner_r
			assign right_key = key_vec[i+1];
		end

		sil_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (occ_vec[i]),
			.left_key  (left_key),
			.left_le   (left_le),
			.right_key (right_key),
			.key       (key_vec[i]),
			.le        (le_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	// read taps: only the first positions are reachable
	for (genvar j = 0; j < RD_N; j++) begin : g_tap
		assign rd_taps[j] = key_vec[j];
	end

	assign past_end = (CW'(in_pos) >= CW'(count_q)) || (32'(in_pos) >= 32'(CAPACITY));

	// form the result word of the operation that finishes this cycle
	always_comb begin
		res_load    = 1'b0;
		res_status  = ST_OK;
		res_value   = '0;
		res_removed = '0;
		res_entry   = OUT_CNT_W'(count_q);
		res_empty   = (count_q == '0);
		if (state_q == S_REMOVE) begin
			res_load    = !any_eq;
			res_removed = OUT_CNT_W'(removed_q);
		end else if (acc) begin
			case (op)
				OP_INSERT: begin
					res_load = 1'b1;
					if (full) begin
						res_status = ST_FULL;
					end else begin
						res_entry = OUT_CNT_W'(count_inc);
						res_empty = 1'b0;
					end
				end
				OP_REMOVE: begin
					res_load = 1'b0;
				end
				OP_READ: begin
					res_load = 1'b1;
					if (past_end) begin
						res_status = ST_PAST_END;
					end else begin
						res_value = rd_taps[in_pos[RD_IW-1:0]];
					end
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end
	end

	// sequence the operation and hold the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			removed_q   <= '0;
			op_key_q    <= '0;
			m_valid_q   <= 1'b0;
			m_status_q  <= ST_OK;
			m_value_q   <= '0;
			m_removed_q <= '0;
			m_entry_q   <= '0;
			m_empty_q   <= 1'b1;
		end else begin
			if (res_load) begin
				m_valid_q   <= 1'b1;
				m_status_q  <= res_status;
				m_value_q   <= res_value;
				m_removed_q <= res_removed;
				m_entry_q   <= res_entry;
				m_empty_q   <= res_empty;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (op)
							OP_INSERT: begin
								if (!full) begin
									count_q <= count_inc;
								end
							end
							OP_REMOVE: begin
								op_key_q  <= in_key;
								removed_q <= '0;
								state_q   <= S_REMOVE;
							end
							default: begin
							end
						endcase
					end
				end
				S_REMOVE: begin
					if (any_eq) begin
						count_q   <= count_dec;
						removed_q <= removed_inc;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {5'd0, m_empty_q, m_entry_q, m_removed_q, m_value_q};

	// count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// no new word is taken while a remove is closing its gap
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REMOVE) |-> !s_axis_tready)
		else $error("input accepted during remove");

	// an accepted insert into a list with room grows the count by one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op == OP_INSERT) && !full) |=> (count_q == $past(count_inc)))
		else $error("insert did not grow the count");

	// each remove step drops exactly one entry and counts it
	a_remove_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_REMOVE) && any_eq) |=>
		((count_q == $past(count_dec)) && (removed_q == $past(removed_inc))))
		else $error("remove step out of step with its count");

	// a failed read carries a zero value
	a_past_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (m_status_q == ST_PAST_END)) |-> (m_value_q == '0))
		else $error("past-end read with nonzero value");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import sil_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 80;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]           status;
		logic [KEY_W-1:0]     read_value;
		logic [OUT_CNT_W-1:0] removed_count;
		logic [OUT_CNT_W-1:0] entry_count;
		logic                 is_empty;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // key_value[31:0], position[35:32], zero pad
	logic [1:0]  s_axis_tuser;   // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // read_value[31:0], removed_count[36:32],
	                             // entry_count[41:37], is_empty[42], zero pad
	logic [1:0]  m_axis_tuser;   // status[1:0]

	// shadow copy of the sorted store
	logic signed [KEY_W-1:0] shadow_keys [LIST_DEPTH];
	int                      shadow_count;
	list_result_t            expected_results [$];

	int err_count;
	int cycle_count;
	int tx_max_wait;
	int rx_max_wait;
	int rx_gap_left;
	int rx_hold_left;

	sorted_insertion_list #(
		.CAPACITY(LIST_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// report a mismatch, full text only for the first few
	function automatic void note_error(input string msg);
		if (err_count < 10) begin
			$display("tb_top: mismatch: %s", msg);
		end
		err_count++;
	endfunction

	// apply one operation to the shadow store and return its result word
	function automatic list_result_t predict_list_op(input logic [1:0] op,
			input logic signed [KEY_W-1:0] key, input logic [POS_W-1:0] pos);
		list_result_t res;
		int at;
		int kept;
		int removed;
		res = '0;
		removed = 0;
		case (op)
			OP_INSERT: begin
				if (shadow_count >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					at = 0;
					while (at < shadow_count && shadow_keys[at] <= key) at++;
					for (int i = shadow_count; i > at; i--) shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[at] = key;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				kept = 0;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_keys[i] == key) begin
						removed++;
					end else begin
						shadow_keys[kept] = shadow_keys[i];
						kept++;
					end
				end
				shadow_count = kept;
			end
			OP_READ: begin
				if (int'(pos) >= shadow_count) begin
					res.status = ST_PAST_END;
				end else begin
					res.read_value = shadow_keys[pos];
				end
			end
			default: ;
		endcase
		res.removed_count = removed[OUT_CNT_W-1:0];
		res.entry_count = shadow_count[OUT_CNT_W-1:0];
		res.is_empty = (shadow_count == 0);
		return res;
	endfunction

	// send one word after a random gap, then record its expected result
	task automatic send_list_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = $urandom_range(0, tx_max_wait);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, pos, key};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(predict_list_op(op, key, pos));
	endtask

	// drop valid and hold until every result is back
	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// mostly keys from a narrow pool so removes find matches
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return $urandom;
			default: return 32'($signed($urandom_range(0, 7)) - 4);
		endcase
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return OP_INSERT;
		else if (r < 65) return OP_REMOVE;
		else if (r < 95) return OP_READ;
		else return OP_UNUSED;
	endfunction

	// edges of the key range, empty and full store, duplicates, unused code
	task automatic test_directed();
		tx_max_wait = 0;
		rx_max_wait = 0;
		send_list_op(OP_READ, 32'd0, 4'd0);
		send_list_op(OP_REMOVE, 32'd0, 4'd0);
		send_list_op(OP_UNUSED, 32'hdead_beef, 4'd9);
		send_list_op(OP_INSERT, 32'h8000_0000, 4'd0);
		send_list_op(OP_INSERT, 32'h7fff_ffff, 4'd0);
		send_list_op(OP_INSERT, 32'd0, 4'd0);
		send_list_op(OP_INSERT, 32'hffff_ffff, 4'd0);
		send_list_op(OP_INSERT, 32'd5, 4'd0);
		send_list_op(OP_INSERT, 32'd5, 4'd0);
		send_list_op(OP_INSERT, 32'd5, 4'd0);
		send_list_op(OP_READ, 32'd0, 4'd0);
		send_list_op(OP_READ, 32'd0, 4'd7);
		for (int i = 0; i < 9; i++) send_list_op(OP_INSERT, 32'd7, 4'd0);
		send_list_op(OP_INSERT, 32'd1, 4'd0);
		send_list_op(OP_READ, 32'd0, 4'd15);
		send_list_op(OP_REMOVE, 32'd7, 4'd0);
		send_list_op(OP_REMOVE, 32'd5, 4'd0);
		wait_for_results();
	endtask

	// random mix, idling switched on and off per stretch
	task automatic test_random_mix();
		for (int seg = 0; seg < 6; seg++) begin
			tx_max_wait = $urandom_range(0, 1) ? 19 : 0;
			rx_max_wait = $urandom_range(0, 1) ? 19 : 0;
			for (int i = 0; i < 50; i++) begin
				send_list_op(pick_op(), pick_key(), $urandom_range(0, 15));
			end
		end
		wait_for_results();
	endtask

	// full rate on both sides
	task automatic test_back_to_back();
		tx_max_wait = 0;
		rx_max_wait = 0;
		for (int i = 0; i < 150; i++) begin
			send_list_op(pick_op(), pick_key(), $urandom_range(0, 15));
		end
		wait_for_results();
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_output_stall();
		tx_max_wait = 0;
		rx_max_wait = 3;
		@(posedge clk);
		rx_hold_left = LONG_HOLD;
		for (int i = 0; i < 30; i++) begin
			send_list_op(pick_op(), pick_key(), $urandom_range(0, 15));
		end
		wait_for_results();
	endtask

	// fill to capacity, overflow once, then empty it again
	task automatic test_fill_and_empty();
		for (int round = 0; round < 8; round++) begin
			tx_max_wait = (round % 2) ? 19 : 2;
			rx_max_wait = (round % 3) ? 19 : 0;
			while (shadow_count < LIST_DEPTH) begin
				send_list_op(OP_INSERT, pick_key(), 4'd0);
			end
			send_list_op(OP_INSERT, pick_key(), 4'd0);
			send_list_op(OP_READ, 32'd0, $urandom_range(0, 15));
			while (shadow_count > 0) begin
				send_list_op(OP_REMOVE, shadow_keys[$urandom_range(0, shadow_count - 1)],
					4'd0);
				if ($urandom_range(0, 2) == 0) send_list_op(OP_READ, 32'd0,
					$urandom_range(0, 15));
			end
		end
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		shadow_count = 0;
		err_count = 0;
		tx_max_wait = 0;
		rx_max_wait = 0;
		rx_gap_left = 0;
		rx_hold_left = 0;
		foreach (shadow_keys[i]) shadow_keys[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_mix();
		test_back_to_back();
		test_output_stall();
		test_fill_and_empty();

		repeat (30) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// receiver: long hold first, then the per-word gap, else ready
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else if (rx_gap_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap_left--;
		end else begin
			m_axis_tready <= arst_n;
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rx_gap_left = $urandom_range(0, rx_max_wait);
			got.status = m_axis_tuser;
			got.read_value = m_axis_tdata[31:0];
			got.removed_count = m_axis_tdata[36:32];
			got.entry_count = m_axis_tdata[41:37];
			got.is_empty = m_axis_tdata[42];
			if (expected_results.size() == 0) begin
				note_error($sformatf("unexpected result word %h", m_axis_tdata));
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					note_error($sformatf("status exp %0d got %0d", want.status, got.status));
				if (got.read_value !== want.read_value)
					note_error($sformatf("read_value exp %h got %h",
						want.read_value, got.read_value));
				if (got.removed_count !== want.removed_count)
					note_error($sformatf("removed_count exp %0d got %0d",
						want.removed_count, got.removed_count));
				if (got.entry_count !== want.entry_count)
					note_error($sformatf("entry_count exp %0d got %0d",
						want.entry_count, got.entry_count));
				if (got.is_empty !== want.is_empty)
					note_error($sformatf("is_empty exp %0d got %0d",
						want.is_empty, got.is_empty));
			end
		end
	end

	// bail out if the run hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule

[filelist.f]
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sorted_insertion_list.sv
test/tb_top.sv
